// File: design/tile_quad_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tile quad generator
// Concurrent checks sampled on the rising clock edge, held off during reset.
// ----------------------------------------------------------------------------
`ifndef TILE_QUAD_GENERATOR_CORE_ASSERT_SVH
`define TILE_QUAD_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication
`define TQG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TQG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/tqg_pkg.sv
// ----------------------------------------------------------------------------
// Tile quad generator package
// Shared constants, control structs and table functions.
// ----------------------------------------------------------------------------
package tqg_pkg;

    localparam int PRIORITY_ENTRIES  = 8192;
    localparam int PRIO_AW           = $clog2(PRIORITY_ENTRIES);
    localparam int AUTOTILE_COUNT    = 7;
    localparam int AT_IW             = (AUTOTILE_COUNT > 1) ? $clog2(AUTOTILE_COUNT) : 1;

    localparam int PATTERNS          = 48;   // patterns per autotile, also first autotile id
    localparam int FIRST_TILESET_ID  = 384;
    localparam int AT_SLOTS          = FIRST_TILESET_ID / PATTERNS;
    localparam int TILESET_COL_BITS  = 3;    // 8 tileset columns
    localparam int MAX_PRIORITY      = 5;
    localparam int FRAME_SHIFT       = 4;    // 16 ticks per frame
    localparam int CORNERS           = 4;

    localparam logic [8:0] TILE_SIZE_RESET = 9'd32;

    // input item kinds
    localparam logic [1:0] KIND_DRAW = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_PRIO = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_PRIO_COUNT = 2'd1;
    localparam logic [1:0] CFG_AT_FRAMES  = 2'd2;
    localparam logic [1:0] CFG_AT_KINDS   = 2'd3;

    // autotile kinds
    localparam logic [1:0] AT_ABSENT = 2'd0;
    localparam logic [1:0] AT_SINGLE = 2'd1;
    localparam logic [1:0] AT_FULL   = 2'd2;

    // remainder unit sizes
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 32;
    localparam int DIV_CW = $clog2(DIV_NW + 1);

    typedef struct packed {
        logic        busy;
        logic        done;
    } t_div_stat;

    typedef struct packed {
        logic [2:0]  sel;
        logic [5:0]  pat;
    } t_at_split;

    typedef struct packed {
        logic        full;
        logic [8:0]  layer;
        logic [2:0]  sel;
        logic [5:0]  pat;
        logic [8:0]  ts;
        logic [15:0] sx_base;
        logic [17:0] sy_base;
        logic [15:0] dx;
        logic [15:0] dy;
    } t_tile_ctx;

    // corner sources, one byte per corner: high nibble x, low nibble y, in half tiles
    localparam logic [31:0] CORNER_SRC [PATTERNS] = '{
        32'h24342535, 32'h40342535, 32'h24502535, 32'h40502535,
        32'h24342551, 32'h40342551, 32'h24502551, 32'h40502551,
        32'h24344135, 32'h40344135, 32'h24504135, 32'h40504135,
        32'h24344151, 32'h40344151, 32'h24504151, 32'h40504151,
        32'h04140515, 32'h04500515, 32'h04140551, 32'h04500551,
        32'h22322333, 32'h22322351, 32'h22324133, 32'h22324151,
        32'h44544555, 32'h44544155, 32'h40544555, 32'h40544155,
        32'h26362737, 32'h40362737, 32'h26502737, 32'h40502737,
        32'h04540555, 32'h22322737, 32'h02120313, 32'h02120351,
        32'h42524353, 32'h42524153, 32'h46564757, 32'h40564757,
        32'h06160717, 32'h06500717, 32'h02520353, 32'h02120717,
        32'h06560757, 32'h42524757, 32'h02520757, 32'h00100111
    };

    function automatic logic [7:0] corner_of(input logic [5:0] pat, input logic [1:0] q);
        logic [31:0] row;
        row = (32'(pat) < PATTERNS) ? CORNER_SRC[pat] : 32'd0;
        return 8'(row >> (8 * (CORNERS - 1 - int'(q))));
    endfunction

    // frame count of autotile n, zero read as one
    function automatic logic [3:0] frames_of(input logic [27:0] frames, input logic [2:0] n);
        logic [3:0] f;
        f = 4'(frames >> (4 * int'(n)));
        if (n == 3'd7) begin
            f = 4'd0;
        end
        return (f == 4'd0) ? 4'd1 : f;
    endfunction

    function automatic logic [1:0] kind_of(input logic [13:0] kinds, input logic [2:0] n);
        logic [13:0] s;
        s = kinds >> (2 * int'(n));
        return s[1:0];
    endfunction

    // split an autotile id into slot (autotile number plus one) and pattern
    function automatic t_at_split autotile_split(input logic [8:0] uid);
        t_at_split  r;
        logic [8:0] base;
        r.sel = '0;
        base  = '0;
        for (int k = 1; k < AT_SLOTS; k++) begin
            if (uid >= 9'(PATTERNS * k)) begin
                r.sel = 3'(k);
                base  = 9'(PATTERNS * k);
            end
        end
        r.pat = 6'(uid - base);
        return r;
    endfunction

endpackage

// File: design/tqg_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tqg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tqg_rem_unit.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`include "tile_quad_generator_core_assert.svh"

module tqg_rem_unit import tqg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output t_div_stat         o_stat,
    output logic [DIV_DW-1:0] o_rem
);

    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic [DIV_DW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_num[DIV_NW-1]};
        diff  = trial - {1'b0, r_div};
        n_rem = (trial >= {1'b0, r_div}) ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

    `TQG_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_done, r_rem < r_div,
        "remainder not below divisor")

endmodule

// File: design/tqg_quad_out.sv
// ----------------------------------------------------------------------------
// Quad output stage
// Builds one quad from the tile context and holds it in the output register.
// ----------------------------------------------------------------------------
module tqg_quad_out import tqg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [1:0]  i_quad,
    input  t_tile_ctx   i_ctx,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [8:0]  o_layer,
    output logic [2:0]  o_texture_select,
    output logic [15:0] o_src_x,
    output logic [17:0] o_src_y,
    output logic [8:0]  o_quad_size,
    output logic [15:0] o_dst_x,
    output logic [15:0] o_dst_y,
    output logic        o_last
);

    logic        r_valid;
    logic [8:0]  r_layer;
    logic [2:0]  r_sel;
    logic [15:0] r_src_x;
    logic [17:0] r_src_y;
    logic [8:0]  r_size;
    logic [15:0] r_dst_x;
    logic [15:0] r_dst_y;
    logic        r_last;

    logic [7:0]  half;
    logic [7:0]  corner;
    logic [11:0] off_x;
    logic [11:0] off_y;
    logic [15:0] n_src_x;
    logic [17:0] n_src_y;
    logic [8:0]  n_size;
    logic [15:0] n_dst_x;
    logic [15:0] n_dst_y;
    logic        n_last;

    always_comb begin
        half   = i_ctx.ts[8:1];
        corner = corner_of(i_ctx.pat, i_quad);
        off_x  = 12'(corner[7:4]) * 12'(half);
        off_y  = 12'(corner[3:0]) * 12'(half);
        if (i_ctx.full) begin
            n_src_x = i_ctx.sx_base + 16'(off_x);
            n_src_y = 18'(off_y);
            n_size  = {1'b0, half};
            n_dst_x = i_ctx.dx + (i_quad[0] ? 16'(half) : 16'd0);
            n_dst_y = i_ctx.dy + (i_quad[1] ? 16'(half) : 16'd0);
            n_last  = (i_quad == 2'(CORNERS - 1));
        end else begin
            n_src_x = i_ctx.sx_base;
            n_src_y = i_ctx.sy_base;
            n_size  = i_ctx.ts;
            n_dst_x = i_ctx.dx;
            n_dst_y = i_ctx.dy;
            n_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_layer <= i_ctx.layer;
            r_sel   <= i_ctx.sel;
            r_src_x <= n_src_x;
            r_src_y <= n_src_y;
            r_size  <= n_size;
            r_dst_x <= n_dst_x;
            r_dst_y <= n_dst_y;
            r_last  <= n_last;
        end
    end

    assign o_free           = !r_valid || i_ready;
    assign o_valid          = r_valid;
    assign o_layer          = r_layer;
    assign o_texture_select = r_sel;
    assign o_src_x          = r_src_x;
    assign o_src_y          = r_src_y;
    assign o_quad_size      = r_size;
    assign o_dst_x          = r_dst_x;
    assign o_dst_y          = r_dst_y;
    assign o_last           = r_last;

endmodule

// File: design/tile_quad_generator_core.sv
// ----------------------------------------------------------------------------
// Tile quad generator core
// Turns map tile ids into draw quads; priority table held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one item per transfer: a tile to
//   draw, an animation tick or a priority table write. Output channel
//   (o_valid/i_ready) carries one quad per transfer, o_last marks the final
//   quad of a tile. Dropped tiles produce no transfer at all.
//   Configuration writes (i_cfg_valid/o_cfg_ready) are always taken and must
//   only arrive while the block is idle.
// Sequence, one item at a time:
//   priority write or ignored item: handled in the idle state
//   tile: accept, priority read, setup, then one quad per cycle while the
//   receiver is ready. The first use of an autotile frame after a tick or
//   frame-count write adds a remainder unit pass in the frame state; later
//   tiles reuse the cached frame.
//   tick: form the counter modulus from the frame counts of all autotiles,
//   then wrap, with a remainder pass if the incremented counter reaches it.
// A stalled receiver holds the current quad in the output register and the
// sequencer waits in the emit state. Reset clears the counter, the frame
// cache valid bits and config; the priority RAM holds garbage until written.
// ----------------------------------------------------------------------------
`include "tile_quad_generator_core_assert.svh"

module tile_quad_generator_core import tqg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [27:0]        i_cfg_data,
    // input items
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [15:0] i_tile_id,
    input  logic [7:0]         i_cell_x,
    input  logic [7:0]         i_cell_y,
    input  logic [12:0]        i_prio_index,
    input  logic [2:0]         i_prio_value,
    // quads
    output logic               o_valid,
    input  logic               i_ready,
    output logic [8:0]         o_layer,
    output logic [2:0]         o_texture_select,
    output logic [15:0]        o_src_x,
    output logic [17:0]        o_src_y,
    output logic [8:0]         o_quad_size,
    output logic [15:0]        o_dst_x,
    output logic [15:0]        o_dst_y,
    output logic               o_last
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRIO  = 3'd1;
    localparam logic [2:0] ST_FRAME = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam logic [2:0] ST_MULT  = 3'd5;
    localparam logic [2:0] ST_TICK  = 3'd6;
    localparam logic [2:0] ST_DIVT  = 3'd7;

    // control and configuration
    logic [2:0]                r_state;
    logic [2:0]                n_state;
    logic [8:0]                r_tile_size;
    logic [13:0]               r_prio_count;
    logic [27:0]               r_at_frames;
    logic [13:0]               r_at_kinds;
    logic [31:0]               r_anim;
    logic [AUTOTILE_COUNT-1:0] r_fvalid;
    logic [2:0]                r_mcnt;
    logic [1:0]                r_quad;

    // per-item working registers
    logic [14:0]               r_uid;
    logic [7:0]                r_cx;
    logic [7:0]                r_cy;
    logic                      r_prio_hit;
    logic                      r_tileset;
    logic [2:0]                r_n;
    logic [27:0]               r_mod;
    logic [3:0]                r_fcache [AUTOTILE_COUNT];
    t_tile_ctx                 r_ctx;

    // accept stage
    logic                      in_acc;
    logic                      id_ok;
    logic [14:0]               in_uid;
    logic                      in_hit;
    logic                      ram_re;
    logic                      ram_we;
    logic [2:0]                ram_rdata;

    // priority stage
    logic [2:0]                prio;
    t_at_split                 split;
    logic                      is_tileset;
    logic [2:0]                at_n;
    logic [1:0]                at_kind;
    logic                      drop;
    logic                      fhit;
    logic [3:0]                frames_n;
    logic [8:0]                layer;

    // setup stage
    logic [3:0]                frame;
    logic [14:0]               t_id;
    logic [5:0]                mul_x;
    logic [11:0]               mul_y;
    logic [14:0]               sx_prod;
    logic [20:0]               sy_prod;

    // tick
    logic [31:0]               mod_full;
    logic [32:0]               sum33;
    logic                      fast;

    // remainder unit
    logic                      div_start;
    logic [DIV_NW-1:0]         div_num;
    logic [DIV_DW-1:0]         div_den;
    t_div_stat                 div_stat;
    logic [DIV_DW-1:0]         div_rem;

    // emit
    logic                      out_free;
    logic                      emit_load;
    logic                      emit_last;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;

    always_comb begin
        id_ok  = (i_tile_id >= 16'sd48);
        in_uid = i_tile_id[14:0];
        // ids at or above the loaded count read as priority zero
        in_hit = (32'(in_uid) < PRIORITY_ENTRIES) && ({1'b0, in_uid} < {2'b0, r_prio_count});
        ram_re = in_acc && (i_kind == KIND_DRAW) && id_ok && in_hit;
        ram_we = in_acc && (i_kind == KIND_PRIO) && (32'(i_prio_index) < PRIORITY_ENTRIES);
    end

    tqg_ram #(
        .WIDTH (3),
        .DEPTH (PRIORITY_ENTRIES)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (PRIO_AW'(i_prio_index)),
        .i_wdata (i_prio_value),
        .i_re    (ram_re),
        .i_raddr (PRIO_AW'(in_uid)),
        .o_rdata (ram_rdata)
    );

    // classify the tile once its priority is back from the RAM
    always_comb begin
        prio       = r_prio_hit ? ram_rdata : 3'd0;
        split      = autotile_split(r_uid[8:0]);
        is_tileset = (r_uid >= 15'(FIRST_TILESET_ID));
        at_n       = split.sel - 3'd1;
        at_kind    = kind_of(r_at_kinds, at_n);
        fhit       = r_fvalid[at_n[AT_IW-1:0]];
        frames_n   = frames_of(r_at_frames, at_n);
        layer      = (prio == 3'd0) ? 9'd0 : 9'(r_cy) + 9'(prio);
        drop       = (prio > 3'(MAX_PRIORITY))
                     || (!is_tileset && ((split.sel > 3'(AUTOTILE_COUNT))
                         || ((at_kind != AT_SINGLE) && (at_kind != AT_FULL))));
    end

    // source origin products: tileset column and row, or the frame strip
    always_comb begin
        frame   = r_fcache[r_n[AT_IW-1:0]];
        t_id    = r_uid - 15'(FIRST_TILESET_ID);
        if (r_tileset) begin
            mul_x = 6'(t_id[TILESET_COL_BITS-1:0]);
        end else if (r_ctx.full) begin
            mul_x = 6'(frame) * 6'd3;
        end else begin
            mul_x = 6'(frame);
        end
        mul_y   = r_tileset ? t_id[14:TILESET_COL_BITS] : 12'd0;
        sx_prod = 15'(mul_x) * 15'(r_tile_size);
        sy_prod = 21'(mul_y) * 21'(r_tile_size);
    end

    // the counter wraps at 16 times the product of all frame counts
    always_comb begin
        mod_full = 32'(r_mod) << FRAME_SHIFT;
        sum33    = 33'(r_anim) + 33'd1;
        fast     = (sum33 < 33'(mod_full));
    end

    always_comb begin
        div_start = ((r_state == ST_PRIO) && !drop && !is_tileset && !fhit)
                    || ((r_state == ST_TICK) && !fast);
        if (r_state == ST_TICK) begin
            div_num = sum33;
            div_den = mod_full;
        end else begin
            div_num = DIV_NW'(r_anim >> FRAME_SHIFT);
            div_den = DIV_DW'(frames_n);
        end
    end

    tqg_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    always_comb begin
        emit_load = (r_state == ST_EMIT) && out_free;
        emit_last = r_ctx.full ? (r_quad == 2'(CORNERS - 1)) : 1'b1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_kind)
                        KIND_DRAW: n_state = id_ok ? ST_PRIO : ST_IDLE;
                        KIND_TICK: n_state = ST_MULT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PRIO: begin
                if (drop) begin
                    n_state = ST_IDLE;
                end else if (is_tileset || fhit) begin
                    n_state = ST_SETUP;
                end else begin
                    n_state = ST_FRAME;
                end
            end
            ST_FRAME: begin
                if (div_stat.done) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_EMIT;
            ST_EMIT: begin
                if (emit_load && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MULT: begin
                if (r_mcnt == 3'(AUTOTILE_COUNT - 1)) begin
                    n_state = ST_TICK;
                end
            end
            ST_TICK: n_state = fast ? ST_IDLE : ST_DIVT;
            ST_DIVT: begin
                if (div_stat.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state, configuration, animation counter, frame cache valid bits, quad and modulus step counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tile_size  <= TILE_SIZE_RESET;
            r_prio_count <= '0;
            r_at_frames  <= '0;
            r_at_kinds   <= '0;
            r_anim       <= '0;
            r_fvalid     <= '0;
            r_mcnt       <= '0;
            r_quad       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TILE_SIZE:  r_tile_size  <= i_cfg_data[8:0];
                    CFG_PRIO_COUNT: r_prio_count <= i_cfg_data[13:0];
                    CFG_AT_FRAMES: begin
                        r_at_frames <= i_cfg_data;
                        r_fvalid    <= '0;
                    end
                    CFG_AT_KINDS:   r_at_kinds   <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    r_mcnt <= '0;
                end
                ST_FRAME: begin
                    if (div_stat.done) begin
                        r_fvalid[r_n[AT_IW-1:0]] <= 1'b1;
                    end
                end
                ST_SETUP: begin
                    r_quad <= '0;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_quad <= r_quad + 2'd1;
                    end
                end
                ST_MULT: begin
                    r_mcnt <= r_mcnt + 3'd1;
                end
                ST_TICK: begin
                    if (fast) begin
                        r_anim   <= sum33[31:0];
                        r_fvalid <= '0;
                    end
                end
                ST_DIVT: begin
                    if (div_stat.done) begin
                        r_anim   <= div_rem;
                        r_fvalid <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_uid      <= in_uid;
                    r_cx       <= i_cell_x;
                    r_cy       <= i_cell_y;
                    r_prio_hit <= in_hit;
                    r_mod      <= 28'd1;
                end
            end
            ST_PRIO: begin
                r_tileset     <= is_tileset;
                r_n           <= at_n;
                r_ctx.full    <= !is_tileset && (at_kind == AT_FULL);
                r_ctx.layer   <= layer;
                r_ctx.sel     <= is_tileset ? 3'd0 : split.sel;
                r_ctx.pat     <= split.pat;
                r_ctx.ts      <= r_tile_size;
                r_ctx.dx      <= 16'(17'(r_cx) * 17'(r_tile_size));
                r_ctx.dy      <= 16'(17'(r_cy) * 17'(r_tile_size));
            end
            ST_FRAME: begin
                if (div_stat.done) begin
                    r_fcache[r_n[AT_IW-1:0]] <= div_rem[3:0];
                end
            end
            ST_SETUP: begin
                r_ctx.sx_base <= 16'(sx_prod);
                r_ctx.sy_base <= 18'(sy_prod);
            end
            ST_MULT: begin
                r_mod <= 28'(32'(r_mod) * 32'(frames_of(r_at_frames, r_mcnt)));
            end
            default: ;
        endcase
    end

    tqg_quad_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (emit_load),
        .i_quad           (r_quad),
        .i_ctx            (r_ctx),
        .o_free           (out_free),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_layer          (o_layer),
        .o_texture_select (o_texture_select),
        .o_src_x          (o_src_x),
        .o_src_y          (o_src_y),
        .o_quad_size      (o_quad_size),
        .o_dst_x          (o_dst_x),
        .o_dst_y          (o_dst_y),
        .o_last           (o_last)
    );

    `TQG_ASSERT_IMP(a_div_done_owned, i_clk, i_rst_n, div_stat.done,
        (r_state == ST_FRAME) || (r_state == ST_DIVT), "remainder done with no waiting state")
    `TQG_ASSERT_IMP(a_setup_frame_ready, i_clk, i_rst_n, r_state == ST_SETUP,
        r_tileset || r_fvalid[r_n[AT_IW-1:0]], "setup without a cached frame")
    `TQG_ASSERT_NXT(a_last_quad_idle, i_clk, i_rst_n, emit_load && emit_last,
        (r_state == ST_IDLE) && o_valid && o_last, "final quad not followed by idle")
    `TQG_ASSERT_NXT(a_anim_wrapped, i_clk, i_rst_n, (r_state == ST_DIVT) && div_stat.done,
        r_anim < mod_full, "animation counter left at or above its modulus")

endmodule
